// File: src/sma_pkg.sv
// shared types, codes and sizes for the stack machine executor
// no dependencies
package sma_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int VALUE_WIDTH = 32;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
    localparam int ACTION_W    = 2;
    localparam int PVAL_W      = 32;
    localparam int STATUS_W    = 2;
    localparam int DEPTH_OUT_W = 7;

    typedef logic [ACTION_W-1:0]       t_action;
    typedef logic signed [PVAL_W-1:0]  t_pval;
    typedef logic [STATUS_W-1:0]       t_status;
    typedef logic [DEPTH_OUT_W-1:0]    t_depth_out;
    typedef logic [VALUE_WIDTH-1:0]    t_value;
    typedef logic [ADDR_W-1:0]         t_addr;
    typedef logic [DEPTH_W-1:0]        t_depth;

    localparam t_action ACT_PUSH  = 2'd0;
    localparam t_action ACT_ADD   = 2'd1;
    localparam t_action ACT_SUB   = 2'd2;
    localparam t_action ACT_PRINT = 2'd3;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_UNDER = 2'd1;
    localparam t_status ST_OVER  = 2'd2;

endpackage

// File: src/sma_if.sv
// valid/ready channel interfaces for instruction and result beats
// depends on sma_pkg
interface sma_in_if;
    import sma_pkg::*;

    logic    valid;
    logic    ready;
    t_action action;
    t_pval   push_value;

    modport source (output valid, output action, output push_value, input ready);
    modport sink (input valid, input action, input push_value, output ready);
endinterface

interface sma_out_if;
    import sma_pkg::*;

    logic       valid;
    logic       ready;
    t_pval      printed_value;
    logic       printed;
    t_status    status;
    t_depth_out depth_after;

    modport source (
        output valid, output printed_value, output printed, output status,
        output depth_after, input ready
    );
    modport sink (
        input valid, input printed_value, input printed, input status,
        input depth_after, output ready
    );
endinterface

// File: src/sma_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module sma_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: src/stack_machine_add_sub.sv
// stack machine executor top level: control sequencer, depth counter, result register
// depends on sma_pkg, sma_if and sma_ram
//
// One instruction is in flight at a time. Push and print go through S_RD1 and
// S_DONE on the way to the result beat, add and subtract through S_RD1, S_RD2
// and S_DONE: the stack ram has one read port and registered read data, so
// the two operands of add and subtract are fetched one after the other. A result
// waiting in the output register does not block the next instruction beat; if it
// is still not taken when the next result is ready, that result waits in place.
// Reset clears the depth counter, the state and the output valid but not the
// stack contents, so the block is ready right after reset. Errors (underflow,
// overflow) leave the stack untouched; the result beat's status field reports them.
module stack_machine_add_sub (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sma_in_if.sink    i_in,
    sma_out_if.source o_out
);
    import sma_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD1  = 2'd1;
    localparam logic [1:0] S_RD2  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0] r_state, n_state;
    t_depth     r_depth, n_depth;
    t_action    r_action;
    t_value     r_push;
    t_value     r_a, n_a;
    t_pval      r_pv, n_pv;
    logic       r_printed, n_printed;
    t_status    r_status, n_status;

    logic       r_out_valid, n_out_valid;
    t_pval      r_out_pv;
    logic       r_out_printed;
    t_status    r_out_status;
    t_depth_out r_out_depth;

    logic       accept;
    logic       load_out;
    logic       ram_we;
    t_addr      ram_waddr;
    t_value     ram_wdata;
    t_addr      ram_raddr;
    t_value     ram_rdata;
    t_value     alu_res;

    sma_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign i_in.ready = (r_state == S_IDLE);
    assign accept     = i_in.valid && i_in.ready;
    assign load_out   = (r_state == S_DONE) && (!r_out_valid || o_out.ready);

    // operand b arrives from the ram in S_RD2, a was kept from S_RD1
    assign alu_res = (r_action == ACT_ADD) ? (ram_rdata + r_a) : (ram_rdata - r_a);

    always_comb begin
        ram_raddr = t_addr'(r_depth - t_depth'(1));
        if (r_state == S_RD1) begin
            ram_raddr = t_addr'(r_depth - t_depth'(2));
        end
    end

    always_comb begin
        n_state   = r_state;
        n_depth   = r_depth;
        n_a       = r_a;
        n_pv      = r_pv;
        n_printed = r_printed;
        n_status  = r_status;
        ram_we    = 1'b0;
        ram_waddr = t_addr'(r_depth);
        ram_wdata = r_push;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_pv      = '0;
                    n_printed = 1'b0;
                    n_status  = ST_OK;
                    n_state   = S_RD1;
                end
            end
            S_RD1: begin
                n_state = S_DONE;
                unique case (r_action)
                    ACT_PUSH: begin
                        if (r_depth == t_depth'(STACK_DEPTH)) begin
                            n_status = ST_OVER;
                        end else begin
                            ram_we  = 1'b1;
                            n_depth = r_depth + t_depth'(1);
                        end
                    end
                    ACT_ADD, ACT_SUB: begin
                        if (r_depth < t_depth'(2)) begin
                            n_status = ST_UNDER;
                        end else begin
                            n_a     = ram_rdata;
                            n_state = S_RD2;
                        end
                    end
                    default: begin
                        if (r_depth == '0) begin
                            n_status = ST_UNDER;
                        end else begin
                            n_pv      = PVAL_W'(ram_rdata);
                            n_printed = 1'b1;
                            n_depth   = r_depth - t_depth'(1);
                        end
                    end
                endcase
            end
            S_RD2: begin
                ram_we    = 1'b1;
                ram_waddr = t_addr'(r_depth - t_depth'(2));
                ram_wdata = alu_res;
                n_depth   = r_depth - t_depth'(1);
                n_state   = S_DONE;
            end
            default: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    assign n_out_valid = load_out || (r_out_valid && !o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_depth     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_depth     <= n_depth;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action <= i_in.action;
            r_push   <= VALUE_WIDTH'(i_in.push_value);
        end
        r_a       <= n_a;
        r_pv      <= n_pv;
        r_printed <= n_printed;
        r_status  <= n_status;
        if (load_out) begin
            r_out_pv      <= r_pv;
            r_out_printed <= r_printed;
            r_out_status  <= r_status;
            r_out_depth   <= DEPTH_OUT_W'(r_depth);
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.printed_value = r_out_pv;
    assign o_out.printed       = r_out_printed;
    assign o_out.status        = r_out_status;
    assign o_out.depth_after   = r_out_depth;

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= t_depth'(STACK_DEPTH))
        else $error("stack depth beyond capacity");

    a_printed_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.printed |-> o_out.status == ST_OK)
        else $error("print beat flagged with error status");

    a_depth_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_DONE) |=> r_depth == $past(r_depth))
        else $error("depth changed outside execute states");

    a_write_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> r_state == S_RD1 || r_state == S_RD2)
        else $error("stack write outside execute states");
endmodule

// File: bench/testbench.sv
// testbench for stack_machine_add_sub: a scoreboard class keeps its own stack model and
// checks every result beat against it; plain tasks drive directed and random streams
// depends on sma_pkg, sma_if and the rtl of the block
module testbench;
    import sma_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 7;
    localparam int RANDOM_ITEMS = 1400;
    localparam int LONG_HOLD    = 300;
    localparam int END_CYCLES   = 20;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        t_pval      printed_value;
        logic       printed;
        t_status    status;
        t_depth_out depth_after;
    } t_result;

    class stack_scoreboard;
        t_value      stack_mem[STACK_DEPTH];
        int unsigned depth = 0;
        int unsigned peak_depth = 0;
        t_result     expected_results[$];
        int unsigned mismatches = 0;
        int unsigned results_checked = 0;
        int unsigned action_count[4] = '{0, 0, 0, 0};
        int unsigned underflows = 0;
        int unsigned overflows = 0;

        // executes one accepted instruction on the model stack
        function void note_instr(t_action act, t_pval val);
            t_result exp_res;
            t_value  op_a;
            t_value  op_b;
            exp_res = '0;
            exp_res.status = ST_OK;
            action_count[act]++;
            case (act)
                ACT_PUSH: begin
                    if (depth >= STACK_DEPTH) begin
                        exp_res.status = ST_OVER;
                    end else begin
                        stack_mem[depth] = t_value'(val);
                        depth++;
                    end
                end
                ACT_ADD, ACT_SUB: begin
                    if (depth < 2) begin
                        exp_res.status = ST_UNDER;
                    end else begin
                        op_a = stack_mem[depth-1];
                        op_b = stack_mem[depth-2];
                        stack_mem[depth-2] = (act == ACT_ADD) ? op_b + op_a : op_b - op_a;
                        depth--;
                    end
                end
                ACT_PRINT: begin
                    if (depth == 0) begin
                        exp_res.status = ST_UNDER;
                    end else begin
                        depth--;
                        exp_res.printed_value = t_pval'(stack_mem[depth]);
                        exp_res.printed = 1'b1;
                    end
                end
            endcase
            if (exp_res.status == ST_UNDER) underflows++;
            if (exp_res.status == ST_OVER) overflows++;
            if (depth > peak_depth) peak_depth = depth;
            exp_res.depth_after = t_depth_out'(depth);
            expected_results = {expected_results, exp_res};
        endfunction

        function void flag(string what, t_result want, t_result got);
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
                $display("mismatch at result %0d: %s", results_checked, what);
                $display("  expected value %0d printed %0b status %0d depth %0d",
                         want.printed_value, want.printed, want.status, want.depth_after);
                $display("  actual   value %0d printed %0b status %0d depth %0d",
                         got.printed_value, got.printed, got.status, got.depth_after);
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (expected_results.size() == 0) begin
                flag("result beat with nothing expected", '0, got);
                return;
            end
            want = expected_results.pop_front();
            results_checked++;
            if (got.printed_value !== want.printed_value || got.printed !== want.printed ||
                got.status !== want.status || got.depth_after !== want.depth_after)
                flag("field differs", want, got);
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   tx_steady;
    bit   rx_steady;
    bit   long_hold_req;
    int unsigned cycle_count;
    stack_scoreboard sb;

    sma_in_if  in_ch ();
    sma_out_if out_ch ();

    stack_machine_add_sub i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    initial begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic t_pval pick_value();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'hFFFF_FFFF;
            3: return t_pval'($urandom_range(0, 1));
            default: return $urandom();
        endcase
    endfunction

    function automatic t_action pick_action(int unsigned push_pct);
        if ($urandom_range(0, 99) < push_pct) return ACT_PUSH;
        case ($urandom_range(0, 2))
            0: return ACT_ADD;
            1: return ACT_SUB;
            default: return ACT_PRINT;
        endcase
    endfunction

    // call at a rising edge; returns at the edge where the beat is taken, or after the idle gap that may follow it
    task automatic send_instr(t_action act, t_pval val);
        int unsigned gap;
        in_ch.valid      <= 1'b1;
        in_ch.action     <= act;
        in_ch.push_value <= val;
        do @(posedge clk); while (in_ch.ready !== 1'b1);
        sb.note_instr(act, val);
        if (!tx_steady && $urandom_range(0, 3) == 0) begin
            gap = pick_gap();
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (sb.expected_results.size() != 0);
    endtask

    initial begin : result_sink
        int unsigned idle_left;
        t_result     got_res;
        idle_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
                got_res.printed_value = out_ch.printed_value;
                got_res.printed       = out_ch.printed;
                got_res.status        = out_ch.status;
                got_res.depth_after   = out_ch.depth_after;
                sb.check_result(got_res);
            end
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                idle_left = LONG_HOLD;
            end
            if (idle_left > 0) begin
                out_ch.ready <= 1'b0;
                idle_left--;
            end else begin
                out_ch.ready <= 1'b1;
                if (!rx_steady && $urandom_range(0, 2) == 0) idle_left = pick_gap();
            end
        end
    end

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results still expected",
                 cycle_count, sb.expected_results.size());
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin : stimulus
        int unsigned sent;
        int unsigned phase_len;
        int unsigned push_pct;
        sb = new();
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        long_hold_req = 1'b0;
        rst_n            <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.action     <= ACT_PUSH;
        in_ch.push_value <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // empty and single-entry errors, wraparound both ways, extreme values
        send_instr(ACT_PRINT, $urandom());
        send_instr(ACT_ADD, $urandom());
        send_instr(ACT_SUB, $urandom());
        send_instr(ACT_PUSH, 32'h7FFF_FFFF);
        send_instr(ACT_ADD, $urandom());
        send_instr(ACT_SUB, $urandom());
        send_instr(ACT_PUSH, 32'h0000_0001);
        send_instr(ACT_ADD, $urandom());
        send_instr(ACT_PUSH, 32'h0000_0001);
        send_instr(ACT_SUB, $urandom());
        send_instr(ACT_PUSH, 32'h8000_0000);
        send_instr(ACT_SUB, $urandom());
        send_instr(ACT_PRINT, $urandom());
        send_instr(ACT_PUSH, 32'hFFFF_FFFF);
        send_instr(ACT_PUSH, 32'hFFFF_FFFF);
        send_instr(ACT_ADD, $urandom());
        send_instr(ACT_PUSH, 32'h0000_0000);
        send_instr(ACT_PRINT, $urandom());
        send_instr(ACT_PRINT, $urandom());
        send_instr(ACT_PRINT, $urandom());
        wait_drained();

        // fill past full while the result side holds off, then empty past zero
        long_hold_req = 1'b1;
        tx_steady = 1'b1;
        while (sb.overflows == 0) send_instr(ACT_PUSH, pick_value());
        send_instr(ACT_PUSH, pick_value());
        tx_steady = 1'b0;
        while (sb.depth > 0) send_instr(ACT_PRINT, pick_value());
        send_instr(ACT_PRINT, pick_value());
        wait_drained();

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 2))
                0: push_pct = 80;
                1: push_pct = 35;
                default: push_pct = 55;
            endcase
            tx_steady = ($urandom_range(0, 4) == 0);
            rx_steady = ($urandom_range(0, 4) == 0);
            phase_len = $urandom_range(20, 120);
            repeat (phase_len) begin
                send_instr(pick_action(push_pct), pick_value());
                sent++;
            end
            if ($urandom_range(0, 3) == 0) wait_drained();
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        wait_drained();
        repeat (END_CYCLES) @(posedge clk);

        $display("run: %0d push, %0d add, %0d sub, %0d print; %0d result beats checked",
                 sb.action_count[ACT_PUSH], sb.action_count[ACT_ADD],
                 sb.action_count[ACT_SUB], sb.action_count[ACT_PRINT], sb.results_checked);
        $display("stack errors: %0d underflow, %0d overflow; deepest stack %0d of %0d",
                 sb.underflows, sb.overflows, sb.peak_depth, STACK_DEPTH);
        if (sb.mismatches == 0 && sb.expected_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches, %0d results missing",
                     sb.mismatches, sb.expected_results.size());
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
